@@ sv/sfl_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the slot free-list registry: table size, field widths,
// request and status codes. No dependencies.
package sfl_pkg;

   localparam int SLOTS       = 4096;
   localparam int HANDLE_BITS = 32;
   localparam int SLOT_W      = $clog2(SLOTS);

   // Fixed field widths of the channels
   localparam int REQ_W    = 3;
   localparam int HANDLE_W = 32;
   localparam int ID_W     = 31;
   localparam int STAGE_W  = 2;
   localparam int ORD_W    = 12;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 12;
   localparam int COUNT_W  = 12;

   localparam logic [HANDLE_W-1:0] HANDLE_MASK =
      (HANDLE_BITS >= HANDLE_W) ? {HANDLE_W{1'b1}}
                                : HANDLE_W'((64'd1 << HANDLE_BITS) - 64'd1);

   localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_UNREGISTER = 3'd1;
   localparam logic [REQ_W-1:0] REQ_ACTIVATE   = 3'd2;
   localparam logic [REQ_W-1:0] REQ_COUNT      = 3'd3;
   localparam logic [REQ_W-1:0] REQ_FIND_NTH   = 3'd4;
   localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

endpackage

@@ sv/sfl_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready) for the registry.
// Depends on sfl_pkg for field widths.
interface sfl_req_if;
   logic                          valid;
   logic                          ready;
   logic [sfl_pkg::REQ_W-1:0]     req_type;
   logic [sfl_pkg::HANDLE_W-1:0]  handle_value;
   logic [sfl_pkg::ID_W-1:0]      slot_id;
   logic [sfl_pkg::STAGE_W-1:0]   texture_stage;
   logic [sfl_pkg::ORD_W-1:0]     ordinal;

   modport source (output valid, req_type, handle_value, slot_id, texture_stage, ordinal,
                   input ready);
   modport sink   (input valid, req_type, handle_value, slot_id, texture_stage, ordinal,
                   output ready);
endinterface

interface sfl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sfl_pkg::STATUS_W-1:0]  status;
   logic [sfl_pkg::INDEX_W-1:0]   slot_index;
   logic [sfl_pkg::HANDLE_W-1:0]  handle_out;
   logic [sfl_pkg::STAGE_W-1:0]   bound_stage;
   logic [sfl_pkg::COUNT_W-1:0]   occupied_count;

   modport source (output valid, status, slot_index, handle_out, bound_stage, occupied_count,
                   input ready);
   modport sink   (input valid, status, slot_index, handle_out, bound_stage, occupied_count,
                   output ready);
endinterface

@@ sv/slot_free_list_registry.sv @@
`timescale 1ns / 1ps
// Slot free-list registry: handle table with a linked free list in block memories.
// Depends on sfl_pkg and the channel interfaces in sfl_if.sv.

// One request is taken at a time and gives exactly one response. Register,
// unregister, activate, count, clear-active and unused codes pass through
// ST_EXEC. The slot memory and the link memory are read at the transfer
// edge. ST_EXEC then modifies, writes back and loads the response register
// once that register is free. Find-nth walks the slot memory's single read
// port one entry per cycle in ST_SCAN, starting at slot 1, until it reaches
// the slot it finds, then loads the response register from ST_FOUND. When
// the ordinal is zero or exceeds the occupied count, find-nth goes through
// ST_EXEC like the others and responds not-found. A new request is taken
// once the previous one has been written to the response register, even if
// the response has not yet been transferred. A response stalled on the
// output holds the block. There is no clearing pass after reset: a
// high-water mark separates never-used slots, whose link and valid values
// are implied, from slots the memories actually hold.
module slot_free_list_registry (
   input  logic        clock,
   input  logic        reset,
   sfl_req_if.sink     req_ch,
   sfl_rsp_if.source   rsp_ch
);

   localparam int SW = sfl_pkg::SLOT_W;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_FOUND} state_type;

   state_type state_ff, state_in;

   // Captured request
   logic [sfl_pkg::REQ_W-1:0]    req_type_ff, req_type_in;
   logic [sfl_pkg::HANDLE_W-1:0] hval_ff, hval_in;
   logic [sfl_pkg::ID_W-1:0]     sid_ff, sid_in;
   logic [sfl_pkg::STAGE_W-1:0]  stage_ff, stage_in;
   logic [sfl_pkg::ORD_W-1:0]    ord_ff, ord_in;

   // Registry state
   logic [SW-1:0]                free_head_ff, free_head_in;
   logic [SW:0]                  hwm_ff, hwm_in;
   logic [SW-1:0]                used_ff, used_in;
   logic [sfl_pkg::ID_W-1:0]     last_ff, last_in;

   // Scan
   logic [SW-1:0]                scan_addr_ff, scan_addr_in;
   logic                         pend_ff, pend_in;
   logic [SW-1:0]                pend_addr_ff, pend_addr_in;
   logic [sfl_pkg::ORD_W-1:0]    cnt_ff, cnt_in;
   logic [SW-1:0]                found_ff, found_in;

   // Response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sfl_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [sfl_pkg::INDEX_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [sfl_pkg::HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [sfl_pkg::STAGE_W-1:0]    rsp_stage_ff, rsp_stage_in;
   logic [sfl_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // Memories: valid bit plus handle, and the free-list links
   logic [sfl_pkg::HANDLE_W:0]   data_mem [sfl_pkg::SLOTS];
   logic [sfl_pkg::HANDLE_W:0]   data_rd_ff;
   logic [SW-1:0]                data_ra;
   logic                         data_we;
   logic [SW-1:0]                data_wa;
   logic [sfl_pkg::HANDLE_W:0]   data_wd;

   logic [SW-1:0]                link_mem [sfl_pkg::SLOTS];
   logic [SW-1:0]                link_rd_ff;
   logic                         link_we;
   logic [SW-1:0]                link_wa;
   logic [SW-1:0]                link_wd;

   // Decode helpers
   logic                         commit_ok;
   logic                         in_range;
   logic [SW-1:0]                slot;
   logic                         cur_valid;
   logic [SW:0]                  head_ext;
   logic [SW-1:0]                next_head;
   logic                         pend_hit;
   logic [sfl_pkg::ORD_W-1:0]    cnt_inc;

   assign req_ch.ready          = (state_ff == ST_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.slot_index     = rsp_slot_ff;
   assign rsp_ch.handle_out     = rsp_handle_ff;
   assign rsp_ch.bound_stage    = rsp_stage_ff;
   assign rsp_ch.occupied_count = rsp_count_ff;

   assign commit_ok = !rsp_valid_ff || rsp_ch.ready;
   assign in_range  = (sid_ff < sfl_pkg::ID_W'(sfl_pkg::SLOTS));
   assign slot      = sid_ff[SW-1:0];
   // Slots at or above the high-water mark were never written and read as free
   assign cur_valid = data_rd_ff[sfl_pkg::HANDLE_W] && ({1'b0, slot} < hwm_ff);
   assign head_ext  = {1'b0, free_head_ff};
   assign next_head = (head_ext >= hwm_ff)
                    ? ((free_head_ff == SW'(sfl_pkg::SLOTS - 1)) ? '0 : free_head_ff + 1'b1)
                    : link_rd_ff;
   assign pend_hit  = pend_ff && data_rd_ff[sfl_pkg::HANDLE_W] && ({1'b0, pend_addr_ff} < hwm_ff);
   assign cnt_inc   = cnt_ff + 1'b1;

   // Hold the read address while a commit waits for the response register
   always_comb begin
      unique case (state_ff)
         ST_IDLE: data_ra = req_ch.slot_id[SW-1:0];
         ST_SCAN: data_ra = scan_addr_ff;
         default: data_ra = slot;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      hval_in       = hval_ff;
      sid_in        = sid_ff;
      stage_in      = stage_ff;
      ord_in        = ord_ff;
      free_head_in  = free_head_ff;
      hwm_in        = hwm_ff;
      used_in       = used_ff;
      last_in       = last_ff;
      scan_addr_in  = scan_addr_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_stage_in  = rsp_stage_ff;
      rsp_count_in  = rsp_count_ff;
      data_we       = 1'b0;
      data_wa       = slot;
      data_wd       = '0;
      link_we       = 1'b0;
      link_wa       = slot;
      link_wd       = free_head_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               req_type_in  = req_ch.req_type;
               hval_in      = req_ch.handle_value & sfl_pkg::HANDLE_MASK;
               sid_in       = req_ch.slot_id;
               stage_in     = req_ch.texture_stage;
               ord_in       = req_ch.ordinal;
               scan_addr_in = SW'(1);
               pend_in      = 1'b0;
               cnt_in       = '0;
               if (req_ch.req_type == sfl_pkg::REQ_FIND_NTH && req_ch.ordinal != '0
                   && req_ch.ordinal <= sfl_pkg::ORD_W'(used_ff)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end

         ST_EXEC: begin
            if (commit_ok) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = sfl_pkg::STATUS_OK;
               rsp_slot_in   = '0;
               rsp_handle_in = '0;
               rsp_stage_in  = '0;
               unique case (req_type_ff)
                  sfl_pkg::REQ_REGISTER: begin
                     if (free_head_ff == '0) begin
                        rsp_status_in = sfl_pkg::STATUS_FULL;
                     end else begin
                        data_we       = 1'b1;
                        data_wa       = free_head_ff;
                        data_wd       = {1'b1, hval_ff};
                        free_head_in  = next_head;
                        if (head_ext >= hwm_ff) begin
                           hwm_in = head_ext + 1'b1;
                        end
                        used_in       = used_ff + 1'b1;
                        rsp_slot_in   = sfl_pkg::INDEX_W'(free_head_ff);
                        rsp_handle_in = hval_ff;
                     end
                  end
                  sfl_pkg::REQ_UNREGISTER: begin
                     if (sid_ff == last_ff) begin
                        last_in = '0;
                     end
                     if (in_range) begin
                        if (slot == '0 || !cur_valid) begin
                           rsp_status_in = sfl_pkg::STATUS_INVALID;
                        end else begin
                           data_we      = 1'b1;
                           data_wd      = '0;
                           link_we      = 1'b1;
                           free_head_in = slot;
                           used_in      = used_ff - 1'b1;
                        end
                     end
                  end
                  sfl_pkg::REQ_ACTIVATE: begin
                     rsp_stage_in = stage_ff;
                     if (!in_range) begin
                        last_in       = sid_ff;
                        rsp_handle_in = sfl_pkg::HANDLE_W'(sid_ff);
                     end else if (slot == '0 || !cur_valid) begin
                        rsp_status_in = sfl_pkg::STATUS_INVALID;
                     end else begin
                        last_in       = sid_ff;
                        rsp_handle_in = data_rd_ff[sfl_pkg::HANDLE_W-1:0];
                     end
                  end
                  sfl_pkg::REQ_COUNT: begin
                     rsp_status_in = sfl_pkg::STATUS_OK;
                  end
                  // Only the no-such-slot case of find-nth comes through here
                  sfl_pkg::REQ_FIND_NTH: begin
                     rsp_status_in = sfl_pkg::STATUS_NOT_FOUND;
                  end
                  sfl_pkg::REQ_CLEAR: begin
                     last_in = '0;
                  end
                  default: begin
                     rsp_status_in = sfl_pkg::STATUS_INVALID;
                  end
               endcase
               rsp_count_in = sfl_pkg::COUNT_W'(used_in);
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle; check the entry read on the cycle before
            scan_addr_in = scan_addr_ff + 1'b1;
            pend_in      = 1'b1;
            pend_addr_in = scan_addr_ff;
            if (pend_hit) begin
               cnt_in = cnt_inc;
               if (cnt_inc == ord_ff) begin
                  found_in = pend_addr_ff;
                  state_in = ST_FOUND;
               end
            end
         end

         ST_FOUND: begin
            if (commit_ok) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = sfl_pkg::STATUS_OK;
               rsp_slot_in   = sfl_pkg::INDEX_W'(found_ff);
               rsp_handle_in = '0;
               rsp_stage_in  = '0;
               rsp_count_in  = sfl_pkg::COUNT_W'(used_ff);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_head_ff <= SW'(1);
         hwm_ff       <= (SW + 1)'(1);
         used_ff      <= '0;
         last_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         hwm_ff       <= hwm_in;
         used_ff      <= used_in;
         last_ff      <= last_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_type_ff   <= req_type_in;
      hval_ff       <= hval_in;
      sid_ff        <= sid_in;
      stage_ff      <= stage_in;
      ord_ff        <= ord_in;
      scan_addr_ff  <= scan_addr_in;
      pend_addr_ff  <= pend_addr_in;
      cnt_ff        <= cnt_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_stage_ff  <= rsp_stage_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[data_wa] <= data_wd;
      end
      data_rd_ff <= data_mem[data_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[free_head_ff];
   end

endmodule
